@@ rtl/prfd_pkg.sv @@
// Shared constants, types and the CRC byte update for the plug radio frame decoder.
`default_nettype none

package prfd_pkg;

  localparam int FRAME_BYTES = 12;
  localparam int CRC_BYTES   = 10;
  localparam int SHIFT_LEN   = FRAME_BYTES - 1;
  localparam int POS_W       = 4;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [POS_W-1:0] LAST_POS  = POS_W'(FRAME_BYTES - 1);
  localparam logic [POS_W-1:0] CRC_LIMIT = POS_W'(CRC_BYTES);

  localparam logic [15:0] CRC_POLY = 16'h8005;

  localparam logic [7:0] CMD_MEASURE = 8'h04;
  localparam logic [7:0] CMD_SWITCH  = 8'h05;
  localparam logic [7:0] CMD_LED     = 8'h06;
  localparam logic [7:0] CMD_PAIRING = 8'h11;
  localparam logic [7:0] FILL_AA     = 8'hAA;
  localparam logic [7:0] FILL_FF     = 8'hFF;
  localparam logic [7:0] DATA_ON     = 8'h01;

  // One complete frame as handed from the front end to the back end.
  typedef struct packed {
    logic [15:0]                  crc_calc;
    logic [FRAME_BYTES-1:0][7:0]  bytes;
  } frame_rec_t;

  // One decoded result.
  typedef struct packed {
    logic        crc_ok;
    logic        from_plug;
    logic [7:0]  channel;
    logic [7:0]  command;
    logic [23:0] device_id;
    logic [7:0]  data_value;
    logic        is_on;
    logic        is_pairing;
    logic        is_on_off;
    logic [15:0] power_tenths_watt;
    logic [15:0] energy_hundredths_kwh;
    logic [15:0] received_crc;
  } result_t;

  // CRC-16, polynomial 0x8005, MSB first, one byte per call.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] r;
    r = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (r[15]) begin
        r = {r[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        r = {r[14:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/prfd_front.sv @@
// Front end: accepts frame bytes, tracks position, runs the CRC and assembles frames.
`default_nettype none

module prfd_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_push,
  input  wire logic [7:0]          in_rx_byte,
  input  wire logic                in_frame_start,
  output logic                     in_full,
  input  wire logic                q_full,
  output logic                     q_push,
  output prfd_pkg::frame_rec_t     q_rec
);
  import prfd_pkg::*;

  logic [POS_W-1:0]          pos_r, pos_nxt, pos_sel;
  logic [15:0]               crc_r, crc_nxt, crc_base;
  logic [SHIFT_LEN-1:0][7:0] shift_r, shift_nxt;
  logic                      accept, last_byte;

  // Stall only when the byte position stands at the last frame byte and the queue has no room.
  assign in_full   = q_full && (pos_r == LAST_POS);
  assign accept    = in_push && !in_full;
  assign pos_sel   = in_frame_start ? '0 : pos_r;
  assign crc_base  = in_frame_start ? 16'h0000 : crc_r;
  assign last_byte = (pos_sel == LAST_POS);
  assign q_push    = accept && last_byte;

  always_comb begin
    pos_nxt   = pos_r;
    crc_nxt   = crc_r;
    shift_nxt = shift_r;
    if (accept) begin
      shift_nxt = {shift_r[SHIFT_LEN-2:0], in_rx_byte};
      if (last_byte) begin
        pos_nxt = '0;
        crc_nxt = 16'h0000;
      end else begin
        pos_nxt = pos_sel + 1'b1;
        crc_nxt = (pos_sel < CRC_LIMIT) ? crc_feed(crc_base, in_rx_byte) : crc_base;
      end
    end
  end

  // The newest byte sits at the low end of the shift line.
  always_comb begin
    q_rec.crc_calc = crc_r;
    for (int i = 0; i < SHIFT_LEN; i++) begin
      q_rec.bytes[i] = shift_r[SHIFT_LEN-1-i];
    end
    q_rec.bytes[FRAME_BYTES-1] = in_rx_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      crc_r <= 16'h0000;
    end else begin
      pos_r <= pos_nxt;
      crc_r <= crc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
  end

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= LAST_POS)
    else $error("byte position beyond last frame byte");

  a_wrap_after_push: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |=> (pos_r == '0) && (crc_r == 16'h0000))
    else $error("position or CRC not cleared after a complete frame");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("frame pushed into a full queue");

endmodule

`default_nettype wire

@@ rtl/prfd_queue.sv @@
// Short frame queue between the front end and the back end.
`default_nettype none

module prfd_queue #(
  parameter int Depth = prfd_pkg::QUEUE_DEPTH
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire prfd_pkg::frame_rec_t wr_rec,
  output logic                      full,
  input  wire logic                 pop,
  output prfd_pkg::frame_rec_t      rd_rec,
  output logic                      empty
);
  import prfd_pkg::*;

  localparam int IDX_W = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CNT_W = $clog2(Depth + 1);

  frame_rec_t       mem [Depth];
  logic [IDX_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(Depth));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_rec  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == IDX_W'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == IDX_W'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_r + CNT_W'(do_push) - CNT_W'(do_pop);
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(Depth))
    else $error("queue count beyond depth");

  a_ptr_agree: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("empty queue with pointers apart");

endmodule

`default_nettype wire

@@ rtl/prfd_back.sv @@
// Back end: decodes a queued frame and holds the result until it is taken.
`default_nettype none

module prfd_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 q_empty,
  input  wire prfd_pkg::frame_rec_t q_rec,
  output logic                      q_pop,
  output prfd_pkg::result_t         res,
  output logic                      out_empty,
  input  wire logic                 out_pop
);
  import prfd_pkg::*;

  result_t res_r, res_nxt;
  logic    valid_r;
  logic    all_ff, all_aa, crc_ok, from_plug, measure;

  assign q_pop = !q_empty && (!valid_r || out_pop);

  always_comb begin
    all_ff  = (q_rec.bytes[6] == FILL_FF) && (q_rec.bytes[7] == FILL_FF) &&
              (q_rec.bytes[8] == FILL_FF) && (q_rec.bytes[9] == FILL_FF);
    all_aa  = (q_rec.bytes[6] == FILL_AA) && (q_rec.bytes[7] == FILL_AA) &&
              (q_rec.bytes[8] == FILL_AA) && (q_rec.bytes[9] == FILL_AA);
    measure = (q_rec.bytes[1] == CMD_MEASURE);
    crc_ok  = ({q_rec.bytes[10], q_rec.bytes[11]} == q_rec.crc_calc);
    from_plug = !((q_rec.bytes[1] == CMD_LED) || all_ff || (measure && all_aa));

    res_nxt.crc_ok       = crc_ok;
    res_nxt.from_plug    = from_plug;
    res_nxt.channel      = q_rec.bytes[0];
    res_nxt.command      = q_rec.bytes[1];
    res_nxt.device_id    = {q_rec.bytes[2], q_rec.bytes[3], q_rec.bytes[4]};
    res_nxt.data_value   = q_rec.bytes[5];
    res_nxt.is_on        = (q_rec.bytes[5] == DATA_ON);
    res_nxt.is_pairing   = (q_rec.bytes[1] == CMD_PAIRING);
    res_nxt.is_on_off    = (q_rec.bytes[1] == CMD_SWITCH);
    res_nxt.received_crc = {q_rec.bytes[10], q_rec.bytes[11]};
    if (crc_ok && from_plug && measure) begin
      res_nxt.power_tenths_watt     = {q_rec.bytes[6], q_rec.bytes[7]};
      res_nxt.energy_hundredths_kwh = {q_rec.bytes[8], q_rec.bytes[9]};
    end else begin
      res_nxt.power_tenths_watt     = 16'h0000;
      res_nxt.energy_hundredths_kwh = 16'h0000;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (q_pop) begin
      valid_r <= 1'b1;
    end else if (out_pop) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res_r <= res_nxt;
    end
  end

  assign res       = res_r;
  assign out_empty = !valid_r;

  a_gated_energy: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !(res_r.crc_ok && res_r.from_plug && res_r.command == CMD_MEASURE)) |->
    (res_r.power_tenths_watt == 16'h0000 && res_r.energy_hundredths_kwh == 16'h0000))
    else $error("power or energy shown for a frame that does not qualify");

endmodule

`default_nettype wire

@@ rtl/plug_radio_frame_decoder_top.sv @@
// Top level of the plug radio frame decoder: front end, frame queue and back end.
`default_nettype none

// Throughput: one byte beat per cycle while in_full is low, with no gaps between frames.
// Result path: the edge that accepts byte 11 writes the frame queue and, when the result
//   register is free, the next edge loads the result register, where the result is visible.
// The input stalls only when byte 11 is due and the frame queue is full.
// Reset (rst_n low, synchronous) clears the byte position, the CRC, the queue pointers and
//   count and the result valid flag; no frame or result survives it.
module plug_radio_frame_decoder_top #(
  parameter int QueueDepth = prfd_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [7:0]  in_rx_byte,
  input  wire logic        in_frame_start,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic             out_crc_ok,
  output logic             out_from_plug,
  output logic [7:0]       out_channel,
  output logic [7:0]       out_command,
  output logic [23:0]      out_device_id,
  output logic [7:0]       out_data_value,
  output logic             out_is_on,
  output logic             out_is_pairing,
  output logic             out_is_on_off,
  output logic [15:0]      out_power_tenths_watt,
  output logic [15:0]      out_energy_hundredths_kwh,
  output logic [15:0]      out_received_crc
);
  import prfd_pkg::*;

  // Front end to queue.
  logic       q_push, q_full;
  frame_rec_t q_wr_rec;

  // Queue to back end.
  logic       q_pop, q_empty;
  frame_rec_t q_rd_rec;

  result_t    res;

  // The front end keeps the byte position and the running CRC, and collects the
  // frame in a shift line so that a complete frame leaves in a single beat.
  prfd_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_rx_byte     (in_rx_byte),
    .in_frame_start (in_frame_start),
    .in_full        (in_full),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_rec          (q_wr_rec)
  );

  // The queue lets the front end keep taking bytes while a result waits to be popped.
  prfd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wr_rec (q_wr_rec),
    .full   (q_full),
    .pop    (q_pop),
    .rd_rec (q_rd_rec),
    .empty  (q_empty)
  );

  // The back end classifies the frame and holds the decoded result.
  prfd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_rec     (q_rd_rec),
    .q_pop     (q_pop),
    .res       (res),
    .out_empty (out_empty),
    .out_pop   (out_pop)
  );

  assign out_crc_ok                = res.crc_ok;
  assign out_from_plug             = res.from_plug;
  assign out_channel               = res.channel;
  assign out_command               = res.command;
  assign out_device_id             = res.device_id;
  assign out_data_value            = res.data_value;
  assign out_is_on                 = res.is_on;
  assign out_is_pairing            = res.is_pairing;
  assign out_is_on_off             = res.is_on_off;
  assign out_power_tenths_watt     = res.power_tenths_watt;
  assign out_energy_hundredths_kwh = res.energy_hundredths_kwh;
  assign out_received_crc          = res.received_crc;

endmodule

`default_nettype wire
